[sv/afq_pkg.sv]
// ---------------------------------------------------------------------------
// afq_pkg
// Shared types and constants for the two-queue frame descriptor merge.
// ---------------------------------------------------------------------------
package afq_pkg;

  // default sizing
  localparam int VIDEO_SLOTS_DEF     = 16;
  localparam int AUDIO_SLOTS_DEF     = 32;
  localparam int MAX_VIDEO_BYTES_DEF = 524288;
  localparam int MAX_AUDIO_BYTES_DEF = 16384;

  // field widths
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;
  localparam int TS_W     = 64;
  localparam int SIZE_W   = 20;
  localparam int ASIZE_W  = 15;
  localparam int GEN_W    = 32;
  localparam int VUSED_W  = 5;
  localparam int AUSED_W  = 6;

  // stream widths
  localparam int IN_DATA_W  = 88;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = 4;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    K_VIDEO_FRAME = 3'd0,
    K_AUDIO_FRAME = 3'd1,
    K_VIDEO_FAIL  = 3'd2,
    K_AUDIO_FAIL  = 3'd3,
    K_DRAIN       = 3'd4,
    K_TOGGLE      = 3'd5
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED    = 3'd0,
    ST_DISABLED  = 3'd1,
    ST_AWAIT_KEY = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_EMITTED   = 3'd4,
    ST_STALE     = 3'd5,
    ST_NOTHING   = 3'd6
  } status_t;

endpackage

[sv/afq_ram.sv]
// ---------------------------------------------------------------------------
// afq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module afq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/afq_queue.sv]
// ---------------------------------------------------------------------------
// afq_queue
// Ring queue of descriptors with the head word always ready to read.
// ---------------------------------------------------------------------------
module afq_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           head,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count_next
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  logic [PW-1:0]    wr_ptr, wr_ptr_next;
  logic [PW-1:0]    rd_ptr, rd_ptr_next;
  logic [CW-1:0]    count;
  logic [WIDTH-1:0] ram_q;
  logic             byp_valid;
  logic [WIDTH-1:0] byp_data;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // pointer and level updates
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      count_next  = count + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      count_next  = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      byp_valid <= 1'b0;
    end else begin
      wr_ptr    <= wr_ptr_next;
      rd_ptr    <= rd_ptr_next;
      count     <= count_next;
      byp_valid <= push && (wr_ptr == rd_ptr_next);
    end
  end

  // word written into the slot being read this cycle bypasses the ram
  always_ff @(posedge clk) begin
    byp_data <= push_data;
  end

  // storage, read address runs one step ahead so the head is registered
  afq_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (wr_ptr),
    .wdata (push_data),
    .raddr (rd_ptr_next),
    .rdata (ram_q)
  );

  assign head = byp_valid ? byp_data : ram_q;

endmodule

[sv/av_frame_queue_merge_resync.sv]
// ---------------------------------------------------------------------------
// av_frame_queue_merge_resync
// Video and audio descriptor queues merged in timestamp order, with
// keyframe resync on the video side and session generations.
// ---------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser carries the request kind and
// tdata the timestamp, frame size, keyframe mark and enable request. Every
// request gives exactly one result on the m_axis channel: tuser carries the
// status and the video mark, tdata the popped descriptor, the resync flag
// and both queue levels after the request.
// A request is taken into an input register, worked through one pass of
// compare and pointer logic and lands in the result register, from which
// it is presented. One request is taken every cycle while the result side
// keeps up; the limit is the single pass that reads both queue heads and
// updates state.
// Each queue holds its descriptors in a ram whose read port prefetches the
// next head, so the head is ready for the next drain.
// Reset empties both queues, turns capture off, sets the resync flag and
// starts the generation at one; ram contents are left as they are.
// When the receiver stalls, the result holds and one further request is
// parked in the input register before s_axis_tready falls.
// ---------------------------------------------------------------------------
module av_frame_queue_merge_resync
  import afq_pkg::*;
#(
  parameter int VIDEO_SLOTS     = VIDEO_SLOTS_DEF,
  parameter int AUDIO_SLOTS     = AUDIO_SLOTS_DEF,
  parameter int MAX_VIDEO_BYTES = MAX_VIDEO_BYTES_DEF,
  parameter int MAX_AUDIO_BYTES = MAX_AUDIO_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // capture_ts[63:0], frame_size[83:64], key_frame[84], enable_request[85]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind[2:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_timestamp[63:0], out_size[83:64], out_keyframe[84],
  // awaiting_keyframe[85], video_used[90:86], audio_used[96:91]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status[2:0], out_is_video[3]
  output logic [OUT_USER_W-1:0] m_axis_tuser
);

  localparam int VW  = GEN_W + 1 + SIZE_W + TS_W;
  localparam int AW  = GEN_W + ASIZE_W + TS_W;
  localparam int VCW = $clog2(VIDEO_SLOTS + 1);
  localparam int ACW = $clog2(AUDIO_SLOTS + 1);
  localparam logic [24:0] VMAX = 25'(MAX_VIDEO_BYTES);
  localparam logic [20:0] AMAX = 21'(MAX_AUDIO_BYTES);

  // input request register
  logic              in_valid;
  logic [KIND_W-1:0] in_kind;
  logic [TS_W-1:0]   in_ts;
  logic [SIZE_W-1:0] in_size;
  logic              in_key;
  logic              in_en;
  logic              go;

  // block state
  logic             capture_on, capture_on_next;
  logic             need_key, need_key_next;
  logic [GEN_W-1:0] gen, gen_next;

  // queue interface
  logic               v_push, v_pop, a_push, a_pop;
  logic [VW-1:0]      v_wdata, v_head;
  logic [AW-1:0]      a_wdata, a_head;
  logic               v_full, v_empty, a_full, a_empty;
  logic [VCW-1:0]     v_count_next;
  logic [ACW-1:0]     a_count_next;
  logic [SIZE_W-1:0]  v_size_sat;
  logic [ASIZE_W-1:0] a_size_sat;

  // head fields
  logic [TS_W-1:0]    vh_ts, ah_ts;
  logic [SIZE_W-1:0]  vh_size;
  logic [ASIZE_W-1:0] ah_size;
  logic               vh_key;
  logic [GEN_W-1:0]   vh_gen, ah_gen;

  // step results
  status_t           status;
  logic              o_vid, o_key;
  logic [TS_W-1:0]   o_ts;
  logic [SIZE_W-1:0] o_size;

  // result register
  logic               m_valid;
  status_t            r_status;
  logic               r_vid, r_key, r_await;
  logic [TS_W-1:0]    r_ts;
  logic [SIZE_W-1:0]  r_size;
  logic [VUSED_W-1:0] r_vused;
  logic [AUSED_W-1:0] r_aused;

  assign go            = in_valid && (!m_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || go;

  // input request capture
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (go) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind <= s_axis_tuser[KIND_W-1:0];
      in_ts   <= s_axis_tdata[63:0];
      in_size <= s_axis_tdata[83:64];
      in_key  <= s_axis_tdata[84];
      in_en   <= s_axis_tdata[85];
    end
  end

  // size saturation and descriptor packing
  assign v_size_sat = ({5'b0, in_size} > VMAX) ? VMAX[SIZE_W-1:0] : in_size;
  assign a_size_sat = ({1'b0, in_size} > AMAX) ? AMAX[ASIZE_W-1:0] : in_size[ASIZE_W-1:0];
  assign v_wdata    = {gen, in_key, v_size_sat, in_ts};
  assign a_wdata    = {gen, a_size_sat, in_ts};

  assign vh_ts   = v_head[TS_W-1:0];
  assign vh_size = v_head[TS_W +: SIZE_W];
  assign vh_key  = v_head[TS_W + SIZE_W];
  assign vh_gen  = v_head[VW-1 -: GEN_W];
  assign ah_ts   = a_head[TS_W-1:0];
  assign ah_size = a_head[TS_W +: ASIZE_W];
  assign ah_gen  = a_head[AW-1 -: GEN_W];

  // request decode and state update
  always_comb begin
    status          = ST_NOTHING;
    v_push          = 1'b0;
    v_pop           = 1'b0;
    a_push          = 1'b0;
    a_pop           = 1'b0;
    capture_on_next = capture_on;
    need_key_next   = need_key;
    gen_next        = gen;
    o_vid           = 1'b0;
    o_key           = 1'b0;
    o_ts            = '0;
    o_size          = '0;
    case (kind_t'(in_kind))
      K_VIDEO_FRAME: begin
        if (!capture_on) begin
          status = ST_DISABLED;
        end else if (need_key && !in_key) begin
          status = ST_AWAIT_KEY;
        end else if (!v_full) begin
          v_push        = go;
          need_key_next = 1'b0;
          status        = ST_QUEUED;
        end else begin
          need_key_next = 1'b1;
          status        = ST_OVERFLOW;
        end
      end
      K_AUDIO_FRAME: begin
        if (!capture_on) begin
          status = ST_DISABLED;
        end else if (!a_full) begin
          a_push = go;
          status = ST_QUEUED;
        end else begin
          status = ST_OVERFLOW;
        end
      end
      K_VIDEO_FAIL: begin
        if (!capture_on) begin
          status = ST_DISABLED;
        end else begin
          need_key_next = 1'b1;
        end
      end
      K_AUDIO_FAIL: begin
        if (!capture_on) begin
          status = ST_DISABLED;
        end
      end
      K_DRAIN: begin
        // older head wins, video on a tie
        if (!v_empty && (a_empty || vh_ts <= ah_ts)) begin
          v_pop  = go;
          o_vid  = 1'b1;
          o_ts   = vh_ts;
          o_size = vh_size;
          o_key  = vh_key;
          status = (vh_gen == gen) ? ST_EMITTED : ST_STALE;
        end else if (!a_empty) begin
          a_pop  = go;
          o_ts   = ah_ts;
          o_size = SIZE_W'(ah_size);
          status = (ah_gen == gen) ? ST_EMITTED : ST_STALE;
        end
      end
      K_TOGGLE: begin
        if (in_en != capture_on) begin
          gen_next        = gen + 1'b1;
          need_key_next   = 1'b1;
          capture_on_next = in_en;
        end
      end
      default: begin
        status = ST_NOTHING;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_on <= 1'b0;
      need_key   <= 1'b1;
      gen        <= GEN_W'(1);
    end else if (go) begin
      capture_on <= capture_on_next;
      need_key   <= need_key_next;
      gen        <= gen_next;
    end
  end

  // descriptor queues
  afq_queue #(
    .WIDTH (VW),
    .DEPTH (VIDEO_SLOTS)
  ) u_video_q (
    .clk        (clk),
    .rst        (rst),
    .push       (v_push),
    .push_data  (v_wdata),
    .pop        (v_pop),
    .head       (v_head),
    .full       (v_full),
    .empty      (v_empty),
    .count_next (v_count_next)
  );

  afq_queue #(
    .WIDTH (AW),
    .DEPTH (AUDIO_SLOTS)
  ) u_audio_q (
    .clk        (clk),
    .rst        (rst),
    .push       (a_push),
    .push_data  (a_wdata),
    .pop        (a_pop),
    .head       (a_head),
    .full       (a_full),
    .empty      (a_empty),
    .count_next (a_count_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (go) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      r_status <= status;
      r_vid    <= o_vid;
      r_key    <= o_key;
      r_ts     <= o_ts;
      r_size   <= o_size;
      r_await  <= need_key_next;
      r_vused  <= VUSED_W'(v_count_next);
      r_aused  <= AUSED_W'(a_count_next);
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tuser  = {r_vid, r_status};
  assign m_axis_tdata  = {7'b0, r_aused, r_vused, r_await, r_key, r_size, r_ts};

endmodule

[sv/afq_checker.sv]
// ---------------------------------------------------------------------------
// afq_checker
// Port-level checks on the result stream of the descriptor merge.
// ---------------------------------------------------------------------------
module afq_checker
  import afq_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  logic [STATUS_W-1:0] st;
  logic                popped;

  assign st     = m_axis_tuser[STATUS_W-1:0];
  assign popped = (st == ST_EMITTED) || (st == ST_STALE);

  // a stalled result holds still
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // descriptor fields are zero unless an entry was popped
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !popped |->
      m_axis_tuser[3] == 1'b0 && m_axis_tdata[84:0] == '0)
    else $error("descriptor fields set without a pop");

  // keyframe mark only comes from the video queue
  a_key_video: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[84] |-> m_axis_tuser[3])
    else $error("keyframe mark on an audio entry");

  // a frame dropped for resync leaves the resync flag set
  a_await_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && st == ST_AWAIT_KEY |-> m_axis_tdata[85])
    else $error("resync flag clear after a resync drop");

endmodule

bind av_frame_queue_merge_resync afq_checker u_afq_checker (.*);

[tb/av_frame_queue_merge_resync_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// av_frame_queue_merge_resync_tb
// Self-checking bench for the video/audio descriptor merge with resync.
// Requests are fed from a queue by a clocked driver, and every accepted
// request is run through a local model of both ring queues, the keyframe
// gate and the session generation. A clocked monitor checks each result
// against the oldest prediction, field by field. Both stream sides idle at
// random, and the result side holds off for long stretches to back up the
// input.
// ---------------------------------------------------------------------------
module av_frame_queue_merge_resync_tb
  import afq_pkg::*;
();

  // request kinds the block ignores
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam logic [TS_W-1:0]   TS_MAX        = {TS_W{1'b1}};
  localparam logic [SIZE_W-1:0] SIZE_MAX      = {SIZE_W{1'b1}};
  localparam int                RANDOM_TARGET = 1400;
  localparam int                HOLD_CYCLES   = 250;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TS_W-1:0]   ts;
    logic [SIZE_W-1:0] size;
    logic              key;
    logic              en;
  } frame_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                is_video;
    logic [TS_W-1:0]     ts;
    logic [SIZE_W-1:0]   size;
    logic                key;
    logic                awaiting;
    logic [VUSED_W-1:0]  vused;
    logic [AUSED_W-1:0]  aused;
  } frame_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // capture_ts[63:0], frame_size[83:64], key_frame[84], enable_request[85]
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // kind[2:0]
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // out_timestamp[63:0], out_size[83:64], out_keyframe[84],
  // awaiting_keyframe[85], video_used[90:86], audio_used[96:91]
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // status[2:0], out_is_video[3]
  logic [OUT_USER_W-1:0] m_axis_tuser;

  av_frame_queue_merge_resync dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  frame_req_t    pending_q[$];
  frame_result_t expected_q[$];
  int            mismatch_n = 0;
  int            result_n = 0;
  int            work_n = 0;
  int            status_seen[8];

  // stimulus-side view of capture state and timestamps
  bit          plan_on = 1'b0;
  logic [63:0] ts_now = '0;
  logic [63:0] last_vts = '0;

  // local copy of both queues and the session state
  logic [TS_W-1:0]    vts_mem [VIDEO_SLOTS_DEF];
  logic [SIZE_W:0]    vsk_mem [VIDEO_SLOTS_DEF];
  logic [GEN_W-1:0]   vgen_mem[VIDEO_SLOTS_DEF];
  logic [TS_W-1:0]    ats_mem [AUDIO_SLOTS_DEF];
  logic [ASIZE_W-1:0] asz_mem [AUDIO_SLOTS_DEF];
  logic [GEN_W-1:0]   agen_mem[AUDIO_SLOTS_DEF];
  int                 v_wr = 0, v_rd = 0, v_cnt = 0;
  int                 a_wr = 0, a_rd = 0, a_cnt = 0;
  logic [GEN_W-1:0]   sess_gen = GEN_W'(1);
  bit                 cap_on = 1'b0;
  bit                 need_key = 1'b1;

  // one request through the merge: updates the local queues, returns the result
  function automatic frame_result_t merge_step(input frame_req_t r);
    frame_result_t e;
    logic [SIZE_W-1:0] sz;
    int vslot, aslot;
    bit hv, ha;
    e = '0;
    e.status = ST_NOTHING;
    case (r.kind)
      K_VIDEO_FRAME: begin
        if (!cap_on) begin
          e.status = ST_DISABLED;
        end else if (need_key && !r.key) begin
          e.status = ST_AWAIT_KEY;
        end else if (v_cnt < VIDEO_SLOTS_DEF) begin
          sz = (r.size > MAX_VIDEO_BYTES_DEF) ? SIZE_W'(MAX_VIDEO_BYTES_DEF) : r.size;
          vts_mem[v_wr]  = r.ts;
          vsk_mem[v_wr]  = {r.key, sz};
          vgen_mem[v_wr] = sess_gen;
          v_wr = (v_wr + 1) % VIDEO_SLOTS_DEF;
          v_cnt++;
          need_key = 1'b0;
          e.status = ST_QUEUED;
        end else begin
          // a lost frame, keyframe or not, re-arms the gate
          need_key = 1'b1;
          e.status = ST_OVERFLOW;
        end
      end
      K_AUDIO_FRAME: begin
        if (!cap_on) begin
          e.status = ST_DISABLED;
        end else if (a_cnt < AUDIO_SLOTS_DEF) begin
          sz = (r.size > MAX_AUDIO_BYTES_DEF) ? SIZE_W'(MAX_AUDIO_BYTES_DEF) : r.size;
          ats_mem[a_wr]  = r.ts;
          asz_mem[a_wr]  = sz[ASIZE_W-1:0];
          agen_mem[a_wr] = sess_gen;
          a_wr = (a_wr + 1) % AUDIO_SLOTS_DEF;
          a_cnt++;
          e.status = ST_QUEUED;
        end else begin
          e.status = ST_OVERFLOW;
        end
      end
      K_VIDEO_FAIL: begin
        if (!cap_on) e.status = ST_DISABLED;
        else need_key = 1'b1;
      end
      K_AUDIO_FAIL: begin
        if (!cap_on) e.status = ST_DISABLED;
      end
      K_DRAIN: begin
        hv = (v_cnt != 0);
        ha = (a_cnt != 0);
        vslot = v_rd;
        aslot = a_rd;
        // older timestamp first, video wins a tie
        if (hv && (!ha || vts_mem[vslot] <= ats_mem[aslot])) begin
          e.is_video = 1'b1;
          e.ts     = vts_mem[vslot];
          e.size   = vsk_mem[vslot][SIZE_W-1:0];
          e.key    = vsk_mem[vslot][SIZE_W];
          e.status = (vgen_mem[vslot] == sess_gen) ? ST_EMITTED : ST_STALE;
          v_rd = (v_rd + 1) % VIDEO_SLOTS_DEF;
          v_cnt--;
        end else if (ha) begin
          e.ts     = ats_mem[aslot];
          e.size   = {{(SIZE_W-ASIZE_W){1'b0}}, asz_mem[aslot]};
          e.status = (agen_mem[aslot] == sess_gen) ? ST_EMITTED : ST_STALE;
          a_rd = (a_rd + 1) % AUDIO_SLOTS_DEF;
          a_cnt--;
        end
      end
      K_TOGGLE: begin
        if (r.en != cap_on) begin
          sess_gen = sess_gen + GEN_W'(1);
          need_key = 1'b1;
          cap_on   = r.en;
        end
      end
      default: ;
    endcase
    e.awaiting = need_key;
    e.vused    = v_cnt[VUSED_W-1:0];
    e.aused    = a_cnt[AUSED_W-1:0];
    return e;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_n++;
    $display("%0t ns: result %0d %s: got %0h, expected %0h", $time, result_n, what,
             got, want);
  endtask

  // ---- request building ----
  task automatic add_req(input logic [KIND_W-1:0] kind, input logic [TS_W-1:0] ts,
                         input logic [SIZE_W-1:0] size, input logic key,
                         input logic en);
    frame_req_t r;
    r = '{kind: kind, ts: ts, size: size, key: key, en: en};
    pending_q.push_back(r);
    if (kind == K_TOGGLE) plan_on = en;
    // every request counts toward the random volume
    work_n++;
  endtask

  task automatic add_frame(input bit is_video, input bit key);
    logic [SIZE_W-1:0] sz;
    logic [TS_W-1:0]   ts;
    ts_now = ts_now + TS_W'($urandom_range(1, 40000));
    if ($urandom_range(0, 19) == 0) sz = SIZE_W'($urandom);
    else if (is_video) sz = SIZE_W'($urandom_range(100, 200000));
    else sz = SIZE_W'($urandom_range(16, 4000));
    if (is_video) begin
      ts = ts_now;
      last_vts = ts;
      add_req(K_VIDEO_FRAME, ts, sz, key, 1'($urandom));
    end else begin
      // audio sometimes shares the last video timestamp, to hit ties
      ts = ($urandom_range(0, 9) == 0) ? last_vts : ts_now - TS_W'($urandom_range(0, 30000));
      add_req(K_AUDIO_FRAME, ts, sz, 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic add_ctrl(input logic [KIND_W-1:0] kind, input logic en);
    add_req(kind, {$urandom, $urandom}, SIZE_W'($urandom), 1'($urandom), en);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---- driver ----
  frame_req_t cur_req;
  int         send_gap = 0;
  int         send_burst = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(merge_step(cur_req));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_req = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, cur_req.en, cur_req.key, cur_req.size, cur_req.ts};
          s_axis_tuser  <= cur_req.kind;
          // gap before the next request: mostly short, a few long, some bursts
          if (send_burst > 0) begin
            send_burst--;
            send_gap = 0;
          end else begin
            if ($urandom_range(0, 99) < 2) send_burst = $urandom_range(30, 90);
            send_gap = pick_gap();
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- result side ready, with long hold-offs ----
  int stall_left = 0;
  int recv_burst = 0;
  int hold_left = 0;
  int hold_idx = 0;
  int taken_n = 0;
  bit hold_on = 1'b0;

  // long hold-offs, counted in cycles on their own
  always @(posedge clk) begin
    if (rst) begin
      hold_on <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) taken_n++;
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_idx < 2 && taken_n >= 200 + 700 * hold_idx) begin
        hold_left = HOLD_CYCLES;
        hold_idx++;
      end
      hold_on <= (hold_left > 0);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_on) begin
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (recv_burst > 0) begin
          recv_burst--;
        end else begin
          if ($urandom_range(0, 99) < 2) recv_burst = $urandom_range(30, 90);
          else if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
        end
      end
    end
  end

  // ---- monitor ----
  always @(posedge clk) begin
    frame_result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      result_n++;
      status_seen[m_axis_tuser[2:0]]++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, tuser", 64'(m_axis_tuser), 64'(0));
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tuser[2:0] != e.status)
          report_mismatch("status", 64'(m_axis_tuser[2:0]), 64'(e.status));
        if (m_axis_tuser[3] != e.is_video)
          report_mismatch("out_is_video", 64'(m_axis_tuser[3]), 64'(e.is_video));
        if (m_axis_tdata[63:0] != e.ts)
          report_mismatch("out_timestamp", m_axis_tdata[63:0], e.ts);
        if (m_axis_tdata[83:64] != e.size)
          report_mismatch("out_size", 64'(m_axis_tdata[83:64]), 64'(e.size));
        if (m_axis_tdata[84] != e.key)
          report_mismatch("out_keyframe", 64'(m_axis_tdata[84]), 64'(e.key));
        if (m_axis_tdata[85] != e.awaiting)
          report_mismatch("awaiting_keyframe", 64'(m_axis_tdata[85]), 64'(e.awaiting));
        if (m_axis_tdata[90:86] != e.vused)
          report_mismatch("video_used", 64'(m_axis_tdata[90:86]), 64'(e.vused));
        if (m_axis_tdata[96:91] != e.aused)
          report_mismatch("audio_used", 64'(m_axis_tdata[96:91]), 64'(e.aused));
      end
    end
  end

  // ---- stimulus and end of run ----
  initial begin : stimulus
    int sel, n, i;
    foreach (status_seen[k]) status_seen[k] = 0;

    // directed: reset state, disabled capture, ignored kinds
    add_ctrl(K_DRAIN, 1'b0);
    add_req(K_VIDEO_FRAME, 64'd10, 20'd100, 1'b1, 1'b0);
    add_req(K_AUDIO_FRAME, 64'd10, 20'd100, 1'b0, 1'b0);
    add_ctrl(K_VIDEO_FAIL, 1'b0);
    add_ctrl(K_AUDIO_FAIL, 1'b0);
    add_ctrl(K_TOGGLE, 1'b0);
    add_ctrl(KIND_SPARE_LO, 1'b1);
    add_ctrl(KIND_SPARE_HI, 1'b1);
    add_ctrl(K_TOGGLE, 1'b1);
    add_ctrl(K_TOGGLE, 1'b1);
    // resync gate, saturation, extremes and the tie
    add_req(K_VIDEO_FRAME, 64'd100, 20'd1000, 1'b0, 1'b0);
    add_req(K_VIDEO_FRAME, TS_MAX, SIZE_MAX, 1'b1, 1'b1);
    add_req(K_VIDEO_FRAME, 64'd0, 20'd0, 1'b0, 1'b0);
    add_req(K_AUDIO_FRAME, TS_MAX, SIZE_MAX, 1'b1, 1'b1);
    add_ctrl(K_DRAIN, 1'b1);
    add_ctrl(K_DRAIN, 1'b0);
    // capture failures while enabled
    add_ctrl(K_AUDIO_FAIL, 1'b1);
    add_ctrl(K_VIDEO_FAIL, 1'b1);
    add_req(K_VIDEO_FRAME, 64'd3, 20'd50, 1'b0, 1'b1);
    add_req(K_VIDEO_FRAME, 64'd5, SIZE_W'(MAX_VIDEO_BYTES_DEF), 1'b1, 1'b0);
    // new session leaves stale entries behind
    add_ctrl(K_TOGGLE, 1'b0);
    add_ctrl(K_TOGGLE, 1'b1);
    add_ctrl(K_DRAIN, 1'b0);
    add_ctrl(K_DRAIN, 1'b1);
    add_ctrl(K_DRAIN, 1'b0);

    work_n = 0;
    ts_now = TS_W'($urandom);
    while (work_n < RANDOM_TARGET) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        // session change, now and then to the current state
        if ($urandom_range(0, 4) == 0) add_ctrl(K_TOGGLE, plan_on);
        else add_ctrl(K_TOGGLE, !plan_on);
        if ($urandom_range(0, 3) == 0) ts_now = {$urandom, $urandom};
        if (plan_on) add_frame(1'b1, 1'b1);
      end else if (sel < 11) begin
        // fill without draining, to run into overflow
        n = $urandom_range(14, 40);
        for (i = 0; i < n; i++) add_frame(1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0);
      end else if (sel < 19) begin
        n = $urandom_range(5, 40);
        for (i = 0; i < n; i++) add_ctrl(K_DRAIN, 1'($urandom));
      end else if (sel < 23) begin
        add_ctrl($urandom_range(0, 1) ? K_VIDEO_FAIL : K_AUDIO_FAIL, 1'($urandom));
      end else if (sel < 27) begin
        // noise: any kind, any field
        add_req(KIND_W'($urandom), {$urandom, $urandom}, SIZE_W'($urandom), 1'($urandom),
                1'($urandom));
      end else begin
        // ordinary traffic
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) begin
          sel = $urandom_range(0, 99);
          if (sel < 35) add_frame(1'b1, $urandom_range(0, 3) == 0);
          else if (sel < 60) add_frame(1'b0, 1'b0);
          else add_ctrl(K_DRAIN, 1'($urandom));
        end
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // wait for all requests to go in and every result to come back
    @(negedge clk);
    while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);

    $display("checked %0d results: %0d queued, %0d emitted, %0d stale, %0d overflow",
             result_n, status_seen[ST_QUEUED], status_seen[ST_EMITTED],
             status_seen[ST_STALE], status_seen[ST_OVERFLOW]);
    $display("  %0d awaiting keyframe, %0d disabled, %0d no-op, %0d mismatches",
             status_seen[ST_AWAIT_KEY], status_seen[ST_DISABLED],
             status_seen[ST_NOTHING], mismatch_n);
    if (mismatch_n == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #(10_000_000);
    $display("run timed out with %0d results outstanding", expected_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule
